>>> hw/rtl/ipq_pkg.sv
// Package for the indexed priority queue: payload structs, operation codes,
// sequencer states and fixed field widths. No dependencies.
package ipq_pkg;

  localparam int ID_W  = 6;
  localparam int PRI_W = 32;
  localparam int CNT_W = 7;
  localparam int FN_W  = 3;

  // Operation codes
  localparam logic [FN_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FN_W-1:0] FN_RAISE  = 3'd1;
  localparam logic [FN_W-1:0] FN_LOWER  = 3'd2;
  localparam logic [FN_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FN_W-1:0] FN_QUERY  = 3'd4;

  typedef struct packed {
    logic [FN_W-1:0]         func;
    logic [ID_W-1:0]         entry_id;
    logic signed [PRI_W-1:0] priority_in;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic [ID_W-1:0]         removed_id;
    logic signed [PRI_W-1:0] priority_out;
    logic [CNT_W-1:0]        entry_count;
  } out_item_t;

  // Result of the shared compare unit
  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_TOPPRI,
    S_UL_RD,
    S_UL_CHK,
    S_PL_ORD,
    S_PL_PRI,
    S_PL_CMP,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/ipq_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// No dependencies beyond its parameters.
module ipq_ram #(
  parameter int W  = 32,
  parameter int D  = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/ipq_cmp.sv
// Shared signed priority compare unit used by the check and placement steps of the sequencer.
// Depends on ipq_pkg.
module ipq_cmp
  import ipq_pkg::*;
(
  input  logic signed [PRI_W-1:0] a,
  input  logic signed [PRI_W-1:0] b,
  output cmp_res_t                res
);

  // signed Q16.16 compare is a plain two's complement compare
  always_comb begin
    res.gt = (a > b);
    res.lt = (a < b);
  end

endmodule

>>> hw/rtl/indexed_priority_queue_unit.sv
// Indexed priority queue kept as a priority-sorted list in RAM.
// Operations run one at a time, and busy stays high through the result strobe.
// Remove does an unlink scan; insert does a placement walk; raise or lower
// does an unlink scan, then a placement walk. Both walk the order RAM, and
// the placement walk uses the shared compare unit.
// Reset: synchronous; clears count and all presence bits.
module indexed_priority_queue_unit
  import ipq_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  // ids are 6 bits wide, so no more than 64 entries can ever be present
  localparam int IDS = (MAX_ENTRIES < 64) ? MAX_ENTRIES : 64;
  localparam int AW  = $clog2(IDS);
  localparam logic [CNT_W-1:0] IDS_C = CNT_W'(IDS);

  state_t state_r, state_nxt;

  logic [FN_W-1:0]         func_r, func_nxt;
  logic [AW-1:0]           tgt_r, tgt_nxt;
  logic signed [PRI_W-1:0] pri_r, pri_nxt;
  logic [AW-1:0]           mv_r, mv_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    found_r, found_nxt;
  logic                    ok_r, ok_nxt;
  logic [ID_W-1:0]         rid_r, rid_nxt;
  logic signed [PRI_W-1:0] pout_r, pout_nxt;
  logic [IDS-1:0]          present_r, present_nxt;

  // RAM ports
  logic             pr_we, pr_re, or_we, or_re;
  logic [AW-1:0]    pr_wa, pr_ra, or_wa, or_ra;
  logic [PRI_W-1:0] pr_wd, pr_rd;
  logic [AW-1:0]    or_wd, or_rd;

  cmp_res_t cmp;

  logic            in_id_ok, here_in, ins_ok;
  logic [AW-1:0]   in_id;
  logic [CNT_W-1:0] idx_m1, cnt_m1;

  assign in_id    = in_data.entry_id[AW-1:0];
  assign in_id_ok = {1'b0, in_data.entry_id} < IDS_C;
  assign here_in  = in_id_ok && present_r[in_id];
  assign ins_ok   = in_id_ok && !present_r[in_id] && (cnt_r < IDS_C);
  assign idx_m1   = idx_r - CNT_W'(1);
  assign cnt_m1   = cnt_r - CNT_W'(1);

  ipq_ram #(.W(PRI_W), .D(IDS), .AW(AW)) u_pri_ram (
    .clk(clk), .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd),
    .rd_en(pr_re), .rd_addr(pr_ra), .rd_data(pr_rd)
  );

  ipq_ram #(.W(AW), .D(IDS), .AW(AW)) u_ord_ram (
    .clk(clk), .wr_en(or_we), .wr_addr(or_wa), .wr_data(or_wd),
    .rd_en(or_re), .rd_addr(or_ra), .rd_data(or_rd)
  );

  // new priority against the priority read from RAM
  ipq_cmp u_cmp (.a(pri_r), .b($signed(pr_rd)), .res(cmp));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority case (in_data.func)
            FN_INSERT: state_nxt = ins_ok ? S_PL_ORD : S_DONE;
            FN_RAISE,
            FN_LOWER,
            FN_QUERY:  state_nxt = here_in ? S_CHK : S_DONE;
            FN_REMOVE: state_nxt = (cnt_r != '0) ? S_CHK : S_DONE;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_CHK: begin
        priority case (func_r)
          FN_RAISE:  state_nxt = cmp.gt ? S_UL_RD : S_DONE;
          FN_LOWER:  state_nxt = cmp.lt ? S_UL_RD : S_DONE;
          FN_REMOVE: state_nxt = S_TOPPRI;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_TOPPRI: state_nxt = S_UL_RD;
      S_UL_RD: begin
        if (idx_r < cnt_r) begin
          state_nxt = S_UL_CHK;
        end else begin
          state_nxt = (func_r == FN_REMOVE) ? S_DONE : S_PL_ORD;
        end
      end
      S_UL_CHK: state_nxt = S_UL_RD;
      S_PL_ORD: state_nxt = (idx_r == '0) ? S_DONE : S_PL_PRI;
      S_PL_PRI: state_nxt = S_PL_CMP;
      S_PL_CMP: state_nxt = cmp.gt ? S_PL_ORD : S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    func_nxt    = func_r;
    tgt_nxt     = tgt_r;
    pri_nxt     = pri_r;
    mv_nxt      = mv_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    ok_nxt      = ok_r;
    rid_nxt     = rid_r;
    pout_nxt    = pout_r;
    present_nxt = present_r;
    pr_we = 1'b0; pr_wa = tgt_r; pr_wd = pri_r;
    pr_re = 1'b0; pr_ra = or_rd;
    or_we = 1'b0; or_wa = idx_r[AW-1:0]; or_wd = tgt_r;
    or_re = 1'b0; or_ra = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt = in_data.func;
          tgt_nxt  = in_id;
          pri_nxt  = in_data.priority_in;
          ok_nxt   = 1'b0;
          rid_nxt  = '0;
          pout_nxt = '0;
          priority case (in_data.func)
            FN_INSERT: begin
              if (ins_ok) begin
                present_nxt[in_id] = 1'b1;
                pr_we   = 1'b1;
                pr_wa   = in_id;
                pr_wd   = in_data.priority_in;
                idx_nxt = cnt_r;
              end
            end
            FN_RAISE,
            FN_LOWER,
            FN_QUERY: begin
              pr_re = 1'b1;
              pr_ra = in_id;
            end
            FN_REMOVE: begin
              or_re = 1'b1;
              or_ra = '0;
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        priority case (func_r)
          FN_QUERY: begin
            pout_nxt = pr_rd;
            ok_nxt   = 1'b1;
          end
          FN_RAISE,
          FN_LOWER: begin
            if ((func_r == FN_RAISE) ? cmp.gt : cmp.lt) begin
              pr_we     = 1'b1;
              idx_nxt   = '0;
              found_nxt = 1'b0;
            end
          end
          FN_REMOVE: begin
            tgt_nxt = or_rd;
            rid_nxt = ID_W'(or_rd);
            pr_re   = 1'b1;
            pr_ra   = or_rd;
          end
          default: ;
        endcase
      end
      S_TOPPRI: begin
        pout_nxt = pr_rd;
        ok_nxt   = 1'b1;
        present_nxt[tgt_r] = 1'b0;
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      // unlink scan: read each slot, shift left once the target is passed
      S_UL_RD: begin
        if (idx_r < cnt_r) begin
          or_re = 1'b1;
        end else begin
          cnt_nxt = cnt_m1;
          idx_nxt = cnt_m1;
        end
      end
      S_UL_CHK: begin
        if (found_r) begin
          or_we = 1'b1;
          or_wa = idx_m1[AW-1:0];
          or_wd = or_rd;
        end
        if (or_rd == tgt_r) begin
          found_nxt = 1'b1;
        end
        idx_nxt = idx_r + CNT_W'(1);
      end
      // placement walk from the tail toward the head
      S_PL_ORD: begin
        if (idx_r == '0) begin
          or_we   = 1'b1;
          or_wa   = '0;
          cnt_nxt = cnt_r + CNT_W'(1);
          ok_nxt  = 1'b1;
        end else begin
          or_re = 1'b1;
          or_ra = idx_m1[AW-1:0];
        end
      end
      S_PL_PRI: begin
        mv_nxt = or_rd;
        pr_re  = 1'b1;
        pr_ra  = or_rd;
      end
      S_PL_CMP: begin
        or_we = 1'b1;
        if (cmp.gt) begin
          or_wd   = mv_r;
          idx_nxt = idx_m1;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          ok_nxt  = 1'b1;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      present_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      present_r <= present_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    tgt_r   <= tgt_nxt;
    pri_r   <= pri_nxt;
    mv_r    <= mv_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    ok_r    <= ok_nxt;
    rid_r   <= rid_nxt;
    pout_r  <= pout_nxt;
  end

  // result transfer
  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_DONE);
  assign out_data.ok           = ok_r;
  assign out_data.removed_id   = rid_r;
  assign out_data.priority_out = pout_r;
  assign out_data.entry_count  = cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IDS_C) else $error("count exceeds capacity");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not start");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> (cnt_r == $past(cnt_r)))
    else $error("count changed outside an operation");

endmodule
